/* hw/rtl/tbpa_pkg.sv */
// Shared field widths, request codes and status codes of the page allocator.
package tbpa_pkg;

    localparam int PAGE_W  = 14;
    localparam int BLOCK_W = 15;
    localparam int REQ_W   = 2;
    localparam int STAT_W  = 2;
    localparam int QUO_W   = 8;
    localparam int WORD_W  = 64;
    localparam int BIT_W   = 6;
    localparam int PAGE_LIMIT = 1 << PAGE_W;

    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_ALLOC = 2'd2;
    localparam logic [STAT_W-1:0] STAT_RANGE     = 2'd3;

endpackage

/* hw/rtl/tbpa_pgdiv.sv */
// Division of a page number by the group size through a registered reciprocal multiply.
module tbpa_pgdiv
    import tbpa_pkg::*;
#(
    parameter int PAGES_PER_GROUP = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PAGE_W-1:0] dividend,
    output logic              done,
    output logic [QUO_W-1:0]  quotient,
    output logic [PAGE_W-1:0] remainder
);

    // With the shift set to the page width plus the log of the group size, the
    // rounded-up reciprocal gives the exact quotient for every page number.
    localparam int LOG_D = $clog2(PAGES_PER_GROUP);
    localparam int SHIFT = PAGE_W + LOG_D;
    localparam int MW    = PAGE_W + 1;
    localparam int PW    = PAGE_W + MW;
    localparam int RW    = QUO_W + $clog2(PAGES_PER_GROUP + 1);
    localparam longint MAGIC_L = ((longint'(1) << SHIFT) + longint'(PAGES_PER_GROUP) - 1)
                                 / longint'(PAGES_PER_GROUP);
    localparam logic [MW-1:0] MAGIC = MW'(MAGIC_L);

    logic              mul_reg;
    logic              sub_reg;
    logic              done_reg;
    logic [PAGE_W-1:0] num_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [PAGE_W-1:0] rem_reg;
    logic [PW-1:0]     product;
    logic [RW-1:0]     back;

    assign product = PW'(num_reg) * PW'(MAGIC);
    assign back    = RW'(quo_reg) * RW'(PAGES_PER_GROUP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg  <= 1'b0;
            sub_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            mul_reg  <= start;
            sub_reg  <= mul_reg;
            done_reg <= sub_reg;
        end
    end

    // The quotient comes first; the remainder is taken back from it in the next cycle.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
        end
        if (mul_reg)
        begin
            quo_reg <= QUO_W'(product >> SHIFT);
        end
        if (sub_reg)
        begin
            rem_reg <= PAGE_W'(RW'(num_reg) - back);
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* hw/rtl/two_level_bitmap_page_allocator_unit.sv */
// Top level of the two-level bitmap page allocator.
//
// One request beat (req_type, page_number) comes in on in_valid/in_stall and
// exactly one result beat (result_page, is_allocated, file_block, status) goes
// out on out_valid/out_stall. Requests are worked one at a time.
// The page bitmap sits in a synchronous memory of 64-bit words and the
// per-group used counts in a second one; a flip-flop full flag per group
// lets an allocation pick its group combinationally.
// Free and query first divide the page by the group size through a reciprocal
// multiply, then read the bitmap word, and a free of a set bit writes it back
// with that bit cleared; a page past the last group skips the bitmap read.
// Allocate scans the bitmap words of the chosen group in order up to the first
// clear bit, and skips the scan when every group is full. The next request is
// taken only once the block is back in idle after write-back.
// After reset the block clears both memories, one word per cycle, over all
// GROUP_COUNT * ceil(PAGES_PER_GROUP / 64) bitmap words (256 by default) with
// in_stall held high.
// The result sits in an output register; while out_stall holds it, the block
// still accepts and works the next request and waits only at write-back, so
// no state changes until its result can be loaded.
module two_level_bitmap_page_allocator_unit
    import tbpa_pkg::*;
#(
    parameter int GROUP_COUNT     = 16,
    parameter int PAGES_PER_GROUP = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [REQ_W-1:0]   req_type,
    input  logic [PAGE_W-1:0]  page_number,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [PAGE_W-1:0]  result_page,
    output logic               is_allocated,
    output logic [BLOCK_W-1:0] file_block,
    output logic [STAT_W-1:0]  status
);

    localparam int WPG         = (PAGES_PER_GROUP + 63) / 64;
    localparam int TOTAL_WORDS = GROUP_COUNT * WPG;
    localparam int TOTAL_PAGES = GROUP_COUNT * PAGES_PER_GROUP;
    localparam int AW          = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;
    localparam int GW          = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int WW          = $clog2(WPG + 1);
    localparam int CW          = $clog2(PAGES_PER_GROUP + 1);
    localparam int NPW         = $clog2(TOTAL_PAGES + 64);
    localparam int LAST_BITS   = PAGES_PER_GROUP % 64;
    localparam logic [WORD_W-1:0] LAST_MASK = (LAST_BITS == 0) ? {WORD_W{1'b1}} :
        ((WORD_W'(1) << LAST_BITS) - WORD_W'(1));

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DIV  = 4'd2;
    localparam logic [3:0] S_ADDR = 4'd3;
    localparam logic [3:0] S_RD   = 4'd4;
    localparam logic [3:0] S_CHK  = 4'd5;
    localparam logic [3:0] S_FIND = 4'd6;
    localparam logic [3:0] S_BASE = 4'd7;
    localparam logic [3:0] S_SCAN = 4'd8;
    localparam logic [3:0] S_WB   = 4'd9;

    logic [3:0]         state_reg;
    logic [3:0]         state_next;
    logic [AW-1:0]      clr_idx_reg;
    logic [GROUP_COUNT-1:0] full_reg;
    logic               out_valid_reg;

    logic [REQ_W-1:0]   req_reg;
    logic [PAGE_W-1:0]  page_reg;
    logic               oor_reg;
    logic [GW-1:0]      grp_reg;
    logic [AW-1:0]      word_addr_reg;
    logic [BIT_W-1:0]   bit_reg;
    logic [AW-1:0]      base_word_reg;
    logic [NPW-1:0]     base_page_reg;
    logic [WW-1:0]      iss_w_reg;
    logic [WW-1:0]      chk_w_reg;
    logic               rd_pend_reg;

    logic [PAGE_W-1:0]  res_page_reg;
    logic [QUO_W-1:0]   res_q_reg;
    logic               res_alloc_reg;
    logic [STAT_W-1:0]  res_stat_reg;
    logic               wr_en_reg;
    logic [AW-1:0]      waddr_reg;
    logic [WORD_W-1:0]  wdata_reg;
    logic [CW-1:0]      cnt_wdata_reg;

    logic [PAGE_W-1:0]  result_page_reg;
    logic               is_allocated_reg;
    logic [BLOCK_W-1:0] file_block_reg;
    logic [STAT_W-1:0]  status_reg;

    logic [WORD_W-1:0]  bm_mem [TOTAL_WORDS];
    logic [CW-1:0]      cnt_mem [GROUP_COUNT];
    logic [WORD_W-1:0]  bm_rdata_reg;
    logic [CW-1:0]      cnt_rdata_reg;
    logic               bm_we;
    logic [AW-1:0]      bm_waddr;
    logic [WORD_W-1:0]  bm_wdata;
    logic [AW-1:0]      bm_raddr;
    logic               cnt_we;
    logic [GW-1:0]      cnt_waddr;
    logic [CW-1:0]      cnt_wdata;

    logic               in_fire;
    logic               out_load;
    logic               clr_last;
    logic               div_done;
    logic [QUO_W-1:0]   div_quo;
    logic [PAGE_W-1:0]  div_rem;
    logic               page_oor;
    logic               grp_hit;
    logic [GW-1:0]      free_grp;
    logic [WORD_W-1:0]  free_bits;
    logic               zero_hit;
    logic [BIT_W-1:0]   zero_bit;
    logic [NPW-1:0]     new_page;
    logic               issue;
    logic               cur_bit;

    assign in_stall = (state_reg != S_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_load = (state_reg == S_WB) && (!out_valid_reg || !out_stall);
    assign clr_last = (clr_idx_reg == AW'(TOTAL_WORDS - 1));
    assign page_oor = ({18'd0, page_number} >= 32'(TOTAL_PAGES));

    tbpa_pgdiv #(
        .PAGES_PER_GROUP (PAGES_PER_GROUP)
    ) u_pgdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_fire && req_type != REQ_ALLOC),
        .dividend  (page_number),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Lowest group that still has a free page.
    always_comb
    begin
        free_grp = '0;
        for (int i = GROUP_COUNT - 1; i >= 0; i--)
        begin
            if (!full_reg[i])
            begin
                free_grp = GW'(i);
            end
        end
        grp_hit = !(&full_reg);
    end

    // Lowest clear bit of the word just read, ignoring bits past the group end.
    always_comb
    begin
        free_bits = ~bm_rdata_reg;
        if (chk_w_reg == WW'(WPG - 1))
        begin
            free_bits = free_bits & LAST_MASK;
        end
        zero_hit = |free_bits;
        zero_bit = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                zero_bit = BIT_W'(i);
            end
        end
    end

    assign new_page = base_page_reg + NPW'({chk_w_reg, zero_bit});
    assign issue    = (iss_w_reg < WW'(WPG));
    assign cur_bit  = bm_rdata_reg[bit_reg];

    always_comb
    begin
        if (state_reg == S_SCAN && issue)
        begin
            bm_raddr = base_word_reg + AW'(iss_w_reg);
        end
        else
        begin
            bm_raddr = word_addr_reg;
        end
    end

    always_comb
    begin
        if (state_reg == S_CLR)
        begin
            bm_we     = 1'b1;
            bm_waddr  = clr_idx_reg;
            bm_wdata  = '0;
            cnt_we    = (int'(clr_idx_reg) < GROUP_COUNT);
            cnt_waddr = clr_idx_reg[GW-1:0];
            cnt_wdata = '0;
        end
        else
        begin
            bm_we     = out_load && wr_en_reg;
            bm_waddr  = waddr_reg;
            bm_wdata  = wdata_reg;
            cnt_we    = out_load && wr_en_reg;
            cnt_waddr = grp_reg;
            cnt_wdata = cnt_wdata_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            bm_mem[bm_waddr] <= bm_wdata;
        end
        bm_rdata_reg <= bm_mem[bm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rdata_reg <= cnt_mem[grp_reg];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:
            begin
                if (clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (req_type == REQ_ALLOC) ? S_FIND : S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = oor_reg ? S_WB : S_ADDR;
                end
            end
            S_ADDR: state_next = S_RD;
            S_RD:   state_next = S_CHK;
            S_CHK:  state_next = S_WB;
            S_FIND: state_next = grp_hit ? S_BASE : S_WB;
            S_BASE: state_next = S_SCAN;
            S_SCAN:
            begin
                if (rd_pend_reg && (zero_hit || chk_w_reg == WW'(WPG - 1)))
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_idx_reg   <= '0;
            full_reg      <= '0;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLR)
            begin
                clr_idx_reg <= clr_idx_reg + AW'(1);
            end
            if (out_load && wr_en_reg)
            begin
                full_reg[grp_reg] <= (cnt_wdata_reg == CW'(PAGES_PER_GROUP));
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_SCAN)
            begin
                rd_pend_reg <= issue;
            end
            else
            begin
                rd_pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    req_reg   <= req_type;
                    page_reg  <= page_number;
                    oor_reg   <= page_oor;
                    wr_en_reg <= 1'b0;
                end
            end
            S_DIV:
            begin
                res_page_reg  <= page_reg;
                res_q_reg     <= div_quo;
                res_alloc_reg <= 1'b0;
                res_stat_reg  <= STAT_RANGE;
            end
            S_ADDR:
            begin
                word_addr_reg <= AW'(int'(div_quo) * WPG + int'(div_rem >> BIT_W));
                grp_reg       <= GW'(div_quo);
                bit_reg       <= div_rem[BIT_W-1:0];
            end
            S_CHK:
            begin
                waddr_reg     <= word_addr_reg;
                wdata_reg     <= bm_rdata_reg & ~(WORD_W'(1) << bit_reg);
                cnt_wdata_reg <= cnt_rdata_reg - CW'(1);
                case (req_reg)
                    REQ_FREE:
                    begin
                        wr_en_reg     <= cur_bit;
                        res_alloc_reg <= 1'b0;
                        res_stat_reg  <= cur_bit ? STAT_OK : STAT_NOT_ALLOC;
                    end
                    default:
                    begin
                        res_alloc_reg <= cur_bit;
                        res_stat_reg  <= STAT_OK;
                    end
                endcase
            end
            S_FIND:
            begin
                grp_reg       <= free_grp;
                res_page_reg  <= '0;
                res_q_reg     <= '0;
                res_alloc_reg <= 1'b0;
                res_stat_reg  <= STAT_FULL;
            end
            S_BASE:
            begin
                base_word_reg <= AW'(int'(grp_reg) * WPG);
                base_page_reg <= NPW'(int'(grp_reg) * PAGES_PER_GROUP);
                iss_w_reg     <= '0;
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    chk_w_reg <= iss_w_reg;
                    iss_w_reg <= iss_w_reg + WW'(1);
                end
                // A page number past the field width is answered as all full.
                if (rd_pend_reg && zero_hit && int'(new_page) < PAGE_LIMIT)
                begin
                    waddr_reg     <= base_word_reg + AW'(chk_w_reg);
                    wdata_reg     <= bm_rdata_reg | (WORD_W'(1) << zero_bit);
                    cnt_wdata_reg <= cnt_rdata_reg + CW'(1);
                    wr_en_reg     <= 1'b1;
                    res_page_reg  <= PAGE_W'(new_page);
                    res_q_reg     <= QUO_W'(grp_reg);
                    res_alloc_reg <= 1'b1;
                    res_stat_reg  <= STAT_OK;
                end
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            result_page_reg  <= res_page_reg;
            is_allocated_reg <= res_alloc_reg;
            status_reg       <= res_stat_reg;
            if (res_stat_reg == STAT_FULL)
            begin
                file_block_reg <= '0;
            end
            else
            begin
                file_block_reg <= BLOCK_W'(res_page_reg) + BLOCK_W'(2) + BLOCK_W'(res_q_reg);
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_page  = result_page_reg;
    assign is_allocated = is_allocated_reg;
    assign file_block   = file_block_reg;
    assign status       = status_reg;

endmodule

/* bench/tb.sv */
// Self-checking bench for the page allocator: directed table and random traffic.
module tb;
    import tbpa_pkg::*;

    localparam int GROUPS      = 16;
    localparam int PPG         = 1024;
    localparam int WPG         = (PPG + 63) / 64;
    localparam int TOTAL_PAGES = GROUPS * PPG;
    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int RANDOM_BEATS = 1800;

    // Request codes not named by the package; code three behaves as a query.
    localparam logic [REQ_W-1:0] REQ_QUERY     = 2'd2;
    localparam logic [REQ_W-1:0] REQ_QUERY_ALT = 2'd3;

    typedef struct packed {
        logic [PAGE_W-1:0]  page;
        logic               alloc;
        logic [BLOCK_W-1:0] block;
        logic [STAT_W-1:0]  status;
    } answer_t;

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [PAGE_W-1:0] page;
        logic              known;
        answer_t           want;
    } dir_row_t;

    localparam int DIR_ROWS = 24;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{REQ_QUERY,     14'd0,     1'b1, '{14'd0,     1'b0, 15'd2,     STAT_OK}},
        '{REQ_QUERY,     14'd16383, 1'b1, '{14'd16383, 1'b0, 15'd16400, STAT_OK}},
        '{REQ_FREE,      14'd0,     1'b1, '{14'd0,     1'b0, 15'd2,     STAT_NOT_ALLOC}},
        '{REQ_FREE,      14'd16383, 1'b1, '{14'd16383, 1'b0, 15'd16400, STAT_NOT_ALLOC}},
        '{REQ_ALLOC,     14'd16383, 1'b1, '{14'd0,     1'b1, 15'd2,     STAT_OK}},
        '{REQ_ALLOC,     14'd0,     1'b1, '{14'd1,     1'b1, 15'd3,     STAT_OK}},
        '{REQ_QUERY,     14'd1,     1'b1, '{14'd1,     1'b1, 15'd3,     STAT_OK}},
        '{REQ_QUERY_ALT, 14'd0,     1'b1, '{14'd0,     1'b1, 15'd2,     STAT_OK}},
        '{REQ_FREE,      14'd0,     1'b1, '{14'd0,     1'b0, 15'd2,     STAT_OK}},
        '{REQ_QUERY,     14'd0,     1'b1, '{14'd0,     1'b0, 15'd2,     STAT_OK}},
        '{REQ_ALLOC,     14'h2AAA,  1'b1, '{14'd0,     1'b1, 15'd2,     STAT_OK}},
        '{REQ_FREE,      14'd1,     1'b1, '{14'd1,     1'b0, 15'd3,     STAT_OK}},
        '{REQ_FREE,      14'd1,     1'b1, '{14'd1,     1'b0, 15'd3,     STAT_NOT_ALLOC}},
        '{REQ_QUERY_ALT, 14'd16383, 1'b1, '{14'd16383, 1'b0, 15'd16400, STAT_OK}},
        '{REQ_QUERY,     14'd1023,  1'b1, '{14'd1023,  1'b0, 15'd1025,  STAT_OK}},
        '{REQ_QUERY,     14'd1024,  1'b1, '{14'd1024,  1'b0, 15'd1027,  STAT_OK}},
        '{REQ_QUERY,     14'h2AAA,  1'b1, '{14'd10922, 1'b0, 15'd10934, STAT_OK}},
        '{REQ_QUERY,     14'h1555,  1'b1, '{14'd5461,  1'b0, 15'd5468,  STAT_OK}},
        '{REQ_ALLOC,     14'h1555,  1'b0, '0},
        '{REQ_ALLOC,     14'd0,     1'b0, '0},
        '{REQ_FREE,      14'd0,     1'b0, '0},
        '{REQ_QUERY,     14'd2,     1'b0, '0},
        '{REQ_ALLOC,     14'd0,     1'b0, '0},
        '{REQ_FREE,      14'h3FFF,  1'b0, '0}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [REQ_W-1:0]   req_type = '0;
    logic [PAGE_W-1:0]  page_number = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [PAGE_W-1:0]  result_page;
    logic               is_allocated;
    logic [BLOCK_W-1:0] file_block;
    logic [STAT_W-1:0]  status;

    // Mirror of the allocator state.
    logic [WORD_W-1:0] bitmap_words [GROUPS*WPG];
    int unsigned       used_count [GROUPS];
    int unsigned       allocated_pages [$];

    answer_t     pending_answers [$];
    int          mismatch_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int unsigned cycle_count = 0;

    two_level_bitmap_page_allocator_unit #(
        .GROUP_COUNT     (GROUPS),
        .PAGES_PER_GROUP (PPG)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .page_number  (page_number),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_page  (result_page),
        .is_allocated (is_allocated),
        .file_block   (file_block),
        .status       (status)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Applies one request to the mirrored state and returns the answer it earns.
    function automatic answer_t serve_request(logic [REQ_W-1:0] req, logic [PAGE_W-1:0] page);
        answer_t           ans;
        int                g;
        int                w;
        int                b;
        int                valid_bits;
        int unsigned       newpage;
        int unsigned       p;
        int unsigned       widx;
        int unsigned       bidx;
        bit                found;
        logic [WORD_W-1:0] free_bits;
        ans = '0;
        p = {18'd0, page};
        found = 1'b0;
        newpage = 0;
        if (req == REQ_ALLOC)
        begin
            for (g = 0; g < GROUPS; g++)
            begin
                if (used_count[g] < PPG)
                    break;
            end
            if (g < GROUPS)
            begin
                for (w = 0; w < WPG && !found; w++)
                begin
                    free_bits = ~bitmap_words[g*WPG + w];
                    valid_bits = PPG - w * 64;
                    if (valid_bits < 64)
                        free_bits &= (64'd1 << valid_bits) - 64'd1;
                    for (b = 0; b < 64 && !found; b++)
                    begin
                        if (free_bits[b])
                        begin
                            newpage = g * PPG + w * 64 + b;
                            found = 1'b1;
                        end
                    end
                end
            end
            if (found && newpage < PAGE_LIMIT)
            begin
                widx = (newpage / PPG) * WPG + (newpage % PPG) / 64;
                bidx = (newpage % PPG) % 64;
                bitmap_words[widx][bidx] = 1'b1;
                used_count[g]++;
                allocated_pages.push_back(newpage);
                ans.page = newpage[PAGE_W-1:0];
                ans.alloc = 1'b1;
                ans.block = BLOCK_W'(newpage + 2 + newpage / PPG);
                ans.status = STAT_OK;
            end
            else
                ans.status = STAT_FULL;
        end
        else
        begin
            ans.page = page;
            ans.block = BLOCK_W'(p + 2 + p / PPG);
            widx = (p / PPG) * WPG + (p % PPG) / 64;
            bidx = (p % PPG) % 64;
            if (p >= TOTAL_PAGES)
                ans.status = STAT_RANGE;
            else if (req == REQ_FREE)
            begin
                if (bitmap_words[widx][bidx])
                begin
                    bitmap_words[widx][bidx] = 1'b0;
                    used_count[p / PPG]--;
                    for (int i = 0; i < allocated_pages.size(); i++)
                    begin
                        if (allocated_pages[i] == p)
                        begin
                            allocated_pages.delete(i);
                            break;
                        end
                    end
                end
                else
                    ans.status = STAT_NOT_ALLOC;
            end
            else
                ans.alloc = bitmap_words[widx][bidx];
        end
        return ans;
    endfunction

    // Offers one request beat, holds it until taken, then records what must come back.
    task automatic send_request(logic [REQ_W-1:0] req, logic [PAGE_W-1:0] page,
                                logic use_given, answer_t given);
        answer_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        page_number <= page;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = serve_request(req, page);
        if (use_given)
            pending_answers.push_back(given);
        else
            pending_answers.push_back(predicted);
    endtask

    function automatic logic [PAGE_W-1:0] pick_page(int live_pct);
        if (allocated_pages.size() != 0 && $urandom_range(99) < live_pct)
            return PAGE_W'(allocated_pages[$urandom_range(allocated_pages.size() - 1)]);
        return PAGE_W'($urandom_range(TOTAL_PAGES - 1));
    endfunction

    task automatic random_request(int alloc_pct);
        int r;
        r = $urandom_range(99);
        if (r < alloc_pct)
            send_request(REQ_ALLOC, PAGE_W'($urandom), 1'b0, '0);
        else if (r < alloc_pct + 32)
            send_request(REQ_FREE, pick_page(85), 1'b0, '0);
        else if ($urandom_range(1) == 0)
            send_request(REQ_QUERY, pick_page(50), 1'b0, '0);
        else
            send_request(REQ_QUERY_ALT, pick_page(50), 1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        answer_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("result beat with no request waiting: page %0d status %0d",
                       result_page, status);
                mismatch_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (result_page !== want.page)
                begin
                    $error("result_page: expected %0d, got %0d", want.page, result_page);
                    mismatch_count++;
                end
                if (is_allocated !== want.alloc)
                begin
                    $error("is_allocated: expected %0d, got %0d", want.alloc, is_allocated);
                    mismatch_count++;
                end
                if (file_block !== want.block)
                begin
                    $error("file_block: expected %0d, got %0d", want.block, file_block);
                    mismatch_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    mismatch_count++;
                end
            end
        end
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    initial
    begin
        foreach (bitmap_words[i])
            bitmap_words[i] = '0;
        foreach (used_count[i])
            used_count[i] = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 21;
        recv_idle_pct = 47;
        foreach (DIRECTED[i])
            send_request(DIRECTED[i].req, DIRECTED[i].page, DIRECTED[i].known, DIRECTED[i].want);

        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            if (i == RANDOM_BEATS / 3)
            begin
                send_idle_pct = 47;
                recv_idle_pct = 21;
            end
            else if (i == 2 * RANDOM_BEATS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_request(45);
        end

        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (48) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* two_level_bitmap_page_allocator_unit.f */
hw/rtl/tbpa_pkg.sv
hw/rtl/tbpa_pgdiv.sv
hw/rtl/two_level_bitmap_page_allocator_unit.sv
bench/tb.sv
